[rtl/ght_pkg.sv]
// shared types and constants for the generational handle table
// used by generational_handle_table_unit; no dependencies
`default_nettype none
package ght_pkg;

  localparam int unsigned SlotBits = 10;
  localparam int unsigned Slots    = 1 << SlotBits;
  localparam int unsigned GenBits  = 32;
  localparam int unsigned ItemBits = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_STALE = 2'd2,
    STAT_RANGE = 2'd3
  } stat_e;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [SlotBits-1:0] handle_slot;
    logic [GenBits-1:0]  handle_generation;
    logic [ItemBits-1:0] item_value;
    logic [SlotBits-1:0] dense_position;
  } ght_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [SlotBits-1:0] out_slot;
    logic [GenBits-1:0]  out_generation;
    logic [ItemBits-1:0] out_value;
    logic [SlotBits-1:0] item_count;
  } ght_rsp_t;

endpackage
`default_nettype wire

[rtl/generational_handle_table_unit.sv]
// generational handle table over a packed item store
// depends on ght_pkg; four synchronous memories with registered read data
// refused add and out-of-range dense read answer from S_IDLE, add and bad handle
// from S_ONE, others from S_TWO; one word in flight, a new word is taken in the
// cycle its result shows; a clearing pass over all slots after reset holds busy
// high; results show for one cycle on done_o; the receiver cannot stall
`default_nettype none
module generational_handle_table_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire ght_pkg::ght_req_t req_i,
  output ght_pkg::ght_rsp_t    rsp_o,
  output logic                 done_o
);

  localparam int unsigned SB = ght_pkg::SlotBits;
  localparam int unsigned GB = ght_pkg::GenBits;
  localparam int unsigned IB = ght_pkg::ItemBits;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ONE,
    S_TWO
  } state_e;

  state_e state_q;
  logic [SB-1:0] clr_q, count_q, head_q, tail_q;
  logic [1:0]    op_q;
  logic [SB-1:0] hslot_q, slot_q, pos_q, moved_q;
  logic [GB-1:0] hgen_q, gen_q;
  logic [IB-1:0] val_q;
  ght_pkg::ght_rsp_t rsp_q;
  logic done_q;

  // slot memories: {occupied, generation}, next free, dense position
  logic [GB:0]   g_mem [ght_pkg::Slots];
  logic [SB-1:0] n_mem [ght_pkg::Slots];
  logic [SB-1:0] p_mem [ght_pkg::Slots];
  // dense memory: {slot, value}
  logic [SB+IB-1:0] d_mem [ght_pkg::Slots];

  logic [GB:0]      g_rdata_q, g_wd;
  logic [SB-1:0]    n_rdata_q, n_wd, p_rdata_q, p_wd;
  logic [SB+IB-1:0] d_rdata_q, d_wd;
  logic [SB-1:0]    g_ra, g_wa, n_ra, n_wa, p_ra, p_wa, d_ra, d_wa;
  logic             g_we, n_we, p_we, d_we;

  logic          h_ok;
  logic [GB-1:0] gen_inc;

  assign h_ok    = g_rdata_q[GB] && (g_rdata_q[GB-1:0] == hgen_q);
  assign gen_inc = g_rdata_q[GB-1:0] + GB'(1);

  always_comb begin
    g_ra = req_i.handle_slot;
    n_ra = head_q;
    p_ra = req_i.handle_slot;
    d_ra = req_i.dense_position;
    g_we = 1'b0; g_wa = slot_q; g_wd = '0;
    n_we = 1'b0; n_wa = tail_q; n_wd = hslot_q;
    p_we = 1'b0; p_wa = head_q; p_wd = count_q;
    d_we = 1'b0; d_wa = count_q; d_wd = '0;
    case (state_q)
      S_CLEAR: begin
        g_we = 1'b1; g_wa = clr_q; g_wd = '0;
        n_we = 1'b1; n_wa = clr_q; n_wd = clr_q + SB'(1);
      end
      S_IDLE: begin
        if (req_i.opcode == ght_pkg::OP_ADD) begin
          g_ra = head_q;
        end
        if (req_i.opcode == ght_pkg::OP_REMOVE) begin
          d_ra = count_q - SB'(1);
        end
      end
      S_ONE: begin
        case (op_q)
          ght_pkg::OP_ADD: begin
            g_we = 1'b1; g_wa = head_q; g_wd = {1'b1, gen_inc};
            p_we = 1'b1; p_wa = head_q; p_wd = count_q;
            d_we = 1'b1; d_wa = count_q; d_wd = {head_q, val_q};
          end
          ght_pkg::OP_REMOVE: begin
            d_ra = p_rdata_q;
            if (h_ok) begin
              g_we = 1'b1; g_wa = hslot_q; g_wd = {1'b0, g_rdata_q[GB-1:0]};
              n_we = 1'b1; n_wa = tail_q; n_wd = hslot_q;
              p_we = 1'b1; p_wa = d_rdata_q[SB+IB-1:IB]; p_wd = p_rdata_q;
            end
          end
          ght_pkg::OP_LOOKUP: begin
            d_ra = p_rdata_q;
          end
          default: begin
            g_ra = d_rdata_q[SB+IB-1:IB];
          end
        endcase
      end
      S_TWO: begin
        if (op_q == ght_pkg::OP_REMOVE) begin
          d_we = 1'b1; d_wa = pos_q; d_wd = {moved_q, val_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (g_we) g_mem[g_wa] <= g_wd;
    g_rdata_q <= g_mem[g_ra];
  end

  always_ff @(posedge clk_i) begin
    if (n_we) n_mem[n_wa] <= n_wd;
    n_rdata_q <= n_mem[n_ra];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) p_mem[p_wa] <= p_wd;
    p_rdata_q <= p_mem[p_ra];
  end

  always_ff @(posedge clk_i) begin
    if (d_we) d_mem[d_wa] <= d_wd;
    d_rdata_q <= d_mem[d_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      count_q <= '0;
      head_q  <= '0;
      tail_q  <= SB'(ght_pkg::Slots - 1);
      op_q    <= '0;
      hslot_q <= '0;
      hgen_q  <= '0;
      slot_q  <= '0;
      gen_q   <= '0;
      val_q   <= '0;
      pos_q   <= '0;
      moved_q <= '0;
      rsp_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + SB'(1);
          if (clr_q == SB'(ght_pkg::Slots - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op_q    <= req_i.opcode;
            hslot_q <= req_i.handle_slot;
            hgen_q  <= req_i.handle_generation;
            val_q   <= req_i.item_value;
            if (req_i.opcode == ght_pkg::OP_ADD &&
                count_q >= SB'(ght_pkg::Slots - 1)) begin
              rsp_q  <= '{status: ght_pkg::STAT_FULL, item_count: count_q, default: '0};
              done_q <= 1'b1;
            end else if (req_i.opcode == ght_pkg::OP_READ &&
                         req_i.dense_position >= count_q) begin
              rsp_q  <= '{status: ght_pkg::STAT_RANGE, item_count: count_q, default: '0};
              done_q <= 1'b1;
            end else begin
              pos_q   <= req_i.dense_position;
              state_q <= S_ONE;
            end
          end
        end
        S_ONE: begin
          case (op_q)
            ght_pkg::OP_ADD: begin
              rsp_q   <= '{status: ght_pkg::STAT_OK, out_slot: head_q,
                           out_generation: gen_inc, out_value: '0,
                           item_count: count_q + SB'(1)};
              done_q  <= 1'b1;
              head_q  <= n_rdata_q;
              count_q <= count_q + SB'(1);
              state_q <= S_IDLE;
            end
            ght_pkg::OP_REMOVE, ght_pkg::OP_LOOKUP: begin
              if (!h_ok) begin
                rsp_q   <= '{status: ght_pkg::STAT_STALE, item_count: count_q,
                             default: '0};
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                gen_q   <= g_rdata_q[GB-1:0];
                slot_q  <= hslot_q;
                pos_q   <= p_rdata_q;
                moved_q <= d_rdata_q[SB+IB-1:IB];
                val_q   <= d_rdata_q[IB-1:0];
                state_q <= S_TWO;
                if (op_q == ght_pkg::OP_REMOVE) begin
                  tail_q  <= hslot_q;
                  count_q <= count_q - SB'(1);
                end
              end
            end
            default: begin
              slot_q  <= d_rdata_q[SB+IB-1:IB];
              val_q   <= d_rdata_q[IB-1:0];
              state_q <= S_TWO;
            end
          endcase
        end
        S_TWO: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
          if (op_q == ght_pkg::OP_READ) begin
            rsp_q <= '{status: ght_pkg::STAT_OK, out_slot: slot_q,
                       out_generation: g_rdata_q[GB-1:0], out_value: val_q,
                       item_count: count_q};
          end else begin
            rsp_q <= '{status: ght_pkg::STAT_OK, out_slot: slot_q,
                       out_generation: gen_q, out_value: d_rdata_q[IB-1:0],
                       item_count: count_q};
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule
`default_nettype wire
